@@ hw/rtl/keyed_table_extract_min_assert.svh @@
// Assertion macros for the keyed table block.
`ifndef KEYED_TABLE_EXTRACT_MIN_ASSERT_SVH
`define KEYED_TABLE_EXTRACT_MIN_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KTE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define KTE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kte_pkg.sv @@
package kte_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int FKEY_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } kte_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic out_full;
    } kte_sts_t;

endpackage

@@ hw/rtl/keyed_table_extract_min.sv @@
// Channel  Direction  Ports                          Item
// s_       in         s_tvalid s_tready s_tdata      one operation
// m_       out        m_tvalid m_tready m_tdata      one result
//
// An item is taken in, then the stored entries are scanned one by one in the sequential
// key/minimum scan (skipped when the table is empty), then the table is updated.
// aresetn is synchronous, active low; it empties the table and drops any result.
// A result waits in the output register while the next item is taken and scanned;
// only the update step stalls while m_tready holds the old result.
module keyed_table_extract_min (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[1:0], key[17:2], data_value[49:18], zero pad
    input  logic [kte_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], found_key[18:3], found_value[50:19], zero pad
    output logic [kte_pkg::M_TDATA_W-1:0] m_tdata
);

    kte_pkg::kte_cmd_t cmd;
    kte_pkg::kte_sts_t sts;

    kte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kte_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/kte_ctrl.sv @@
module kte_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  kte_pkg::kte_sts_t sts,
    output kte_pkg::kte_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    always_comb begin
        cmd.load   = s_tvalid && s_tready_reg;
        cmd.step   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_COMMIT) && !sts.out_full;
    end

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next    = sts.cnt_zero ? S_COMMIT : S_SCAN;
                    s_tready_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (!sts.out_full) begin
                    state_next    = S_IDLE;
                    s_tready_next = 1'b1;
                end
            end
            default: begin
                state_next    = S_IDLE;
                s_tready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready = s_tready_reg;

endmodule

@@ hw/rtl/kte_dpath.sv @@
module kte_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  kte_pkg::kte_cmd_t                cmd,
    output kte_pkg::kte_sts_t                sts,
    input  logic [kte_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [kte_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [kte_pkg::KEY_BITS-1:0]       key_reg  [kte_pkg::DEPTH];
    logic [kte_pkg::KEY_BITS-1:0]       key_next [kte_pkg::DEPTH];
    logic signed [kte_pkg::VALUE_W-1:0] val_reg  [kte_pkg::DEPTH];
    logic signed [kte_pkg::VALUE_W-1:0] val_next [kte_pkg::DEPTH];
    logic [kte_pkg::CNT_W-1:0]          count_reg, count_next;

    logic [kte_pkg::FUNC_W-1:0]         func_reg;
    logic [kte_pkg::KEY_BITS-1:0]       kin_reg;
    logic signed [kte_pkg::VALUE_W-1:0] vin_reg;
    logic [kte_pkg::IDX_W-1:0]          idx_reg;
    logic                               hit_reg;
    logic [kte_pkg::IDX_W-1:0]          pos_reg;
    logic [kte_pkg::KEY_BITS-1:0]       min_key_reg;
    logic signed [kte_pkg::VALUE_W-1:0] min_val_reg;

    logic                               m_tvalid_reg;
    logic [kte_pkg::STATUS_W-1:0]       out_status_reg;
    logic [kte_pkg::FKEY_W-1:0]         out_key_reg;
    logic signed [kte_pkg::VALUE_W-1:0] out_val_reg;

    logic [kte_pkg::FUNC_W-1:0]         in_func;
    logic [kte_pkg::KEY_BITS-1:0]       in_key;
    logic signed [kte_pkg::VALUE_W-1:0] in_val;

    logic [kte_pkg::KEY_BITS-1:0]       cur_key;
    logic signed [kte_pkg::VALUE_W-1:0] cur_val;
    logic                               key_eq;
    logic                               val_lt;
    logic                               full;

    logic [kte_pkg::STATUS_W-1:0]       res_status;
    logic [kte_pkg::FKEY_W-1:0]         res_key;
    logic signed [kte_pkg::VALUE_W-1:0] res_val;
    logic                               do_ins;
    logic                               do_upd;
    logic                               do_rem;

    assign in_func = s_tdata[1:0];
    assign in_key  = kte_pkg::KEY_BITS'(s_tdata[17:2]);
    assign in_val  = signed'(s_tdata[49:18]);

    assign cur_key = key_reg[idx_reg];
    assign cur_val = val_reg[idx_reg];
    assign key_eq  = (cur_key == kin_reg);
    assign val_lt  = (idx_reg == '0) || (cur_val < min_val_reg);
    assign full    = (count_reg == kte_pkg::CNT_W'(kte_pkg::DEPTH));

    assign sts.cnt_zero  = (count_reg == '0);
    assign sts.scan_last = (idx_reg == kte_pkg::IDX_W'(count_reg - kte_pkg::CNT_W'(1)));
    assign sts.out_full  = m_tvalid_reg && !m_tready;

    always_comb begin
        res_status = kte_pkg::ST_NOTFOUND;
        res_key    = '0;
        res_val    = '0;
        do_ins     = 1'b0;
        do_upd     = 1'b0;
        do_rem     = 1'b0;
        case (func_reg)
            kte_pkg::FUNC_INSERT: begin
                if (hit_reg) begin
                    res_status = kte_pkg::ST_UPDATED;
                    do_upd     = 1'b1;
                end else if (full) begin
                    res_status = kte_pkg::ST_FULL;
                end else begin
                    res_status = kte_pkg::ST_INSERTED;
                    do_ins     = 1'b1;
                end
            end
            kte_pkg::FUNC_DELETE: begin
                if (hit_reg) begin
                    res_status = kte_pkg::ST_REMOVED;
                    do_rem     = 1'b1;
                end
            end
            kte_pkg::FUNC_EXTRACT: begin
                if (sts.cnt_zero) begin
                    res_status = kte_pkg::ST_EMPTY;
                end else begin
                    res_status = kte_pkg::ST_REMOVED;
                    res_key    = kte_pkg::FKEY_W'(min_key_reg);
                    res_val    = min_val_reg;
                    do_rem     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        key_next   = key_reg;
        val_next   = val_reg;
        count_next = count_reg;
        if (cmd.commit && do_ins) begin
            key_next[0] = kin_reg;
            val_next[0] = vin_reg;
            for (int i = 1; i < kte_pkg::DEPTH; i++) begin
                key_next[i] = key_reg[i-1];
                val_next[i] = val_reg[i-1];
            end
            count_next = count_reg + kte_pkg::CNT_W'(1);
        end
        if (cmd.commit && do_upd) begin
            for (int i = 0; i < kte_pkg::DEPTH; i++) begin
                if (kte_pkg::IDX_W'(i) == pos_reg) begin
                    val_next[i] = vin_reg;
                end
            end
        end
        if (cmd.commit && do_rem) begin
            for (int i = 0; i < kte_pkg::DEPTH - 1; i++) begin
                if (kte_pkg::IDX_W'(i) >= pos_reg) begin
                    key_next[i] = key_reg[i+1];
                    val_next[i] = val_reg[i+1];
                end
            end
            count_next = count_reg - kte_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            kin_reg  <= in_key;
            vin_reg  <= in_val;
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
        end else if (cmd.step) begin
            if (func_reg == kte_pkg::FUNC_EXTRACT) begin
                if (val_lt) begin
                    pos_reg     <= idx_reg;
                    min_key_reg <= cur_key;
                    min_val_reg <= cur_val;
                end
            end else if (!hit_reg && key_eq) begin
                hit_reg <= 1'b1;
                pos_reg <= idx_reg;
            end
            idx_reg <= idx_reg + kte_pkg::IDX_W'(1);
        end
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_key_reg    <= res_key;
            out_val_reg    <= res_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_val_reg, out_key_reg, out_status_reg};

endmodule

@@ hw/rtl/kte_checker.sv @@
`include "keyed_table_extract_min_assert.svh"

module kte_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [kte_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kte_pkg::M_TDATA_W-1:0] m_tdata
);

    `KTE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `KTE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `KTE_ASSERT_IMP(a_status_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= kte_pkg::ST_EMPTY, "bad status code")
    `KTE_ASSERT_IMP(a_found_zero, aclk, aresetn, m_tvalid && (m_tdata[2:0] != kte_pkg::ST_REMOVED), m_tdata[50:3] == '0, "found fields set without removal")

endmodule

bind keyed_table_extract_min kte_checker u_kte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
